[sv/escape_time_fractal_periodicity_defines.svh]
// assertion macros shared by the escape-time fractal block
`ifndef ESCAPE_TIME_FRACTAL_PERIODICITY_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PERIODICITY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[sv/etfp_pkg.sv]
// types and constants of the escape-time fractal block
package etfp_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 28;
	localparam int COUNT_BITS = 16;
	localparam int PROD_BITS  = 2 * WORD_BITS;
	localparam int CFG_INDEX_BITS = 8;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS-1:0]        mag_t;
	typedef logic [PROD_BITS-1:0]        prod_t;
	typedef logic [COUNT_BITS-1:0]       count_t;
	typedef logic [CFG_INDEX_BITS-1:0]   cfg_index_t;

	typedef enum logic [1:0] {
		OUT_ESCAPED  = 2'd0,
		OUT_PERIODIC = 2'd1,
		OUT_LIMIT    = 2'd2
	} outcome_t;

	localparam cfg_index_t CFG_MODE     = cfg_index_t'(0);
	localparam cfg_index_t CFG_MAX_ITER = cfg_index_t'(1);
	localparam cfg_index_t CFG_C_REAL   = cfg_index_t'(2);
	localparam cfg_index_t CFG_C_IMAG   = cfg_index_t'(3);

	localparam count_t MAX_ITER_RESET = count_t'(256);

	// exactly 4 with 2*FRAC_BITS fraction bits
	localparam logic [PROD_BITS:0] FOUR_SQ =
		{{(PROD_BITS - 2*FRAC_BITS - 2){1'b0}}, 1'b1, {(2*FRAC_BITS + 2){1'b0}}};

	typedef struct packed {
		word_t point_real;
		word_t point_imag;
	} point_t;

	typedef struct packed {
		outcome_t outcome;
		count_t   step_index;
	} result_t;

endpackage

[sv/etfp_mul.sv]
// shared unsigned multiplier with registered product
module etfp_mul import etfp_pkg::*; (
	input  logic  clk,
	input  mag_t  a,
	input  mag_t  b,
	output prod_t prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= prod_t'(a) * prod_t'(b);
	end

endmodule

[sv/escape_time_fractal_periodicity.sv]
// top level: escape-time iteration with periodic-orbit check
// Usage:
//   Configuration words go in on cfg_valid/cfg_ready (ready is always high)
//   with cfg_index selecting mode, iteration limit or the Julia constant.
//   Write them only while busy is low.
//   A point is taken at a clock edge with start high and busy low; busy
//   stays high until its result is out. done is high for exactly one
//   cycle with the result word on result; the receiver cannot stall it.
//   Each iteration runs through the states MSX, MSY and MXY (three
//   products on the one shared 32x32 multiplier), ESC (the escape test),
//   SCR and SCI (the real and imaginary update on one shared
//   scale-and-saturate unit), then CHK (the match test). done comes high
//   after the ESC state for an escape, after the CHK state for a match,
//   and after CHK of the last iteration when the iterations run out.
//   With an iteration limit of zero, done comes high in the cycle after the
//   start edge and the block stays ready.
//   A new point may be started in the cycle that done is high.
//   Reset drops busy and done and restores the registers to
//   Mandelbrot mode, limit 256, Julia constant zero.
`include "escape_time_fractal_periodicity_defines.svh"

module escape_time_fractal_periodicity import etfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  point_t     point,
	output logic       done,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  cfg_index_t cfg_index,
	input  word_t      cfg_data
);

	localparam int SUM_BITS = PROD_BITS + 3;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MSX  = 8'b0000_0010,
		ST_MSY  = 8'b0000_0100,
		ST_MXY  = 8'b0000_1000,
		ST_ESC  = 8'b0001_0000,
		ST_SCR  = 8'b0010_0000,
		ST_SCI  = 8'b0100_0000,
		ST_CHK  = 8'b1000_0000
	} state_t;

	function automatic mag_t mag_of(word_t v);
		return v[WORD_BITS-1] ? mag_t'(-v) : mag_t'(v);
	endfunction

	state_t  state_q;
	logic    mode_q;
	count_t  max_q;
	word_t   cr_q, ci_q;
	word_t   zx_q, zy_q, cx_q, cy_q, ox_q, oy_q;
	prod_t   sx_q, sy_q, d_q, pp_q;
	logic    rneg_q, ineg_q;
	count_t  i_q;
	logic [COUNT_BITS:0] limit_q;
	logic    done_q;
	result_t result_q;

	logic    accept;
	mag_t    xm, ym, mul_a, mul_b;
	prod_t   prod_q;
	logic [PROD_BITS:0] mag2;
	logic    escape;
	logic    match;
	count_t  i_next;
	logic [COUNT_BITS:0] half_step;

	// shared scale-and-saturate unit
	logic                      sa_neg;
	prod_t                     sa_mag;
	word_t                     sa_c;
	logic signed [PROD_BITS+1:0] sa_ext;
	logic signed [SUM_BITS-1:0]  sa_sum;
	logic                      sa_fits;
	word_t                     sa_out;

	assign accept    = (state_q == ST_IDLE) && start;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

	assign xm    = mag_of(zx_q);
	assign ym    = mag_of(zy_q);
	assign mul_a = (state_q == ST_MSY) ? ym : xm;
	assign mul_b = (state_q == ST_MSX) ? xm : ym;

	etfp_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign mag2   = {1'b0, sx_q} + {1'b0, sy_q};
	assign escape = mag2 > FOUR_SQ;
	assign match  = (zx_q == ox_q) && (zy_q == oy_q);
	assign i_next = i_q + count_t'(1);
	assign half_step = ({1'b0, i_q} + (COUNT_BITS+1)'(1)) >> 1;

	always_comb begin
		sa_neg = (state_q == ST_SCR) ? rneg_q : ineg_q;
		sa_mag = (state_q == ST_SCR) ? d_q : pp_q;
		sa_c   = (state_q == ST_SCR) ? cx_q : cy_q;
		sa_ext = sa_neg ? -$signed({2'b00, sa_mag}) : $signed({2'b00, sa_mag});
		// arithmetic shift gives the floor of the signed product
		sa_sum = SUM_BITS'(sa_ext >>> FRAC_BITS) + SUM_BITS'(sa_c);
		sa_fits = (&sa_sum[SUM_BITS-1:WORD_BITS-1]) || !(|sa_sum[SUM_BITS-1:WORD_BITS-1]);
		if (sa_fits) begin
			sa_out = word_t'(sa_sum[WORD_BITS-1:0]);
		end else if (sa_sum[SUM_BITS-1]) begin
			sa_out = {1'b1, {(WORD_BITS-1){1'b0}}};
		end else begin
			sa_out = {1'b0, {(WORD_BITS-1){1'b1}}};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			max_q  <= MAX_ITER_RESET;
			cr_q   <= '0;
			ci_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:     mode_q <= cfg_data[0];
				CFG_MAX_ITER: max_q  <= count_t'(cfg_data[COUNT_BITS-1:0]);
				CFG_C_REAL:   cr_q   <= cfg_data;
				CFG_C_IMAG:   ci_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			i_q     <= '0;
			limit_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						i_q     <= '0;
						limit_q <= (COUNT_BITS+1)'(2);
						if (max_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_MSX;
						end
					end
				end
				ST_MSX: state_q <= ST_MSY;
				ST_MSY: state_q <= ST_MXY;
				ST_MXY: state_q <= ST_ESC;
				ST_ESC: begin
					if (escape) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCR;
					end
				end
				ST_SCR: state_q <= ST_SCI;
				ST_SCI: state_q <= ST_CHK;
				ST_CHK: begin
					if (match) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if ({1'b0, i_q} > limit_q) begin
							limit_q <= limit_q + half_step;
						end
						i_q <= i_next;
						if (i_next == max_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MSX;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zx_q     <= '0;
			zy_q     <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			d_q      <= '0;
			pp_q     <= '0;
			rneg_q   <= 1'b0;
			ineg_q   <= 1'b0;
			result_q <= '0;
		end else begin
			if (accept) begin
				if (mode_q) begin
					zx_q <= point.point_real;
					zy_q <= point.point_imag;
					ox_q <= point.point_real;
					oy_q <= point.point_imag;
					cx_q <= cr_q;
					cy_q <= ci_q;
				end else begin
					zx_q <= '0;
					zy_q <= '0;
					ox_q <= '0;
					oy_q <= '0;
					cx_q <= point.point_real;
					cy_q <= point.point_imag;
				end
				result_q <= '{outcome: OUT_LIMIT, step_index: max_q};
			end
			if (state_q == ST_MSY) begin
				sx_q <= prod_q;
			end
			if (state_q == ST_MXY) begin
				sy_q <= prod_q;
			end
			if (state_q == ST_ESC) begin
				pp_q   <= prod_q << 1;
				rneg_q <= sx_q < sy_q;
				d_q    <= (sx_q < sy_q) ? (sy_q - sx_q) : (sx_q - sy_q);
				ineg_q <= zx_q[WORD_BITS-1] ^ zy_q[WORD_BITS-1];
				if (escape) begin
					result_q <= '{outcome: OUT_ESCAPED, step_index: i_q};
				end
			end
			if (state_q == ST_SCR) begin
				zx_q <= sa_out;
			end
			if (state_q == ST_SCI) begin
				zy_q <= sa_out;
			end
			if (state_q == ST_CHK) begin
				if (match) begin
					result_q <= '{outcome: OUT_PERIODIC, step_index: i_q};
				end else begin
					if ({1'b0, i_q} > limit_q) begin
						ox_q <= zx_q;
						oy_q <= zy_q;
					end
					if (i_next == max_q) begin
						result_q <= '{outcome: OUT_LIMIT, step_index: max_q};
					end
				end
			end
		end
	end

	`ASSERT_IMPLIES(a_esc_from_test, clk, arst_n, done_q && (result_q.outcome == OUT_ESCAPED), $past(state_q == ST_ESC))
	`ASSERT_IMPLIES(a_match_from_check, clk, arst_n, done_q && (result_q.outcome == OUT_PERIODIC), $past(state_q == ST_CHK))
	`ASSERT_NEXT(a_saved_hold, clk, arst_n, (state_q != ST_CHK) && !accept, $stable(ox_q) && $stable(oy_q))
	`ASSERT_NEXT(a_count_hold, clk, arst_n, (state_q != ST_CHK) && !accept, $stable(i_q) && $stable(limit_q))

endmodule
